>>> rtl/bhe_pkg.sv
// bhe_pkg: shared types and constants of the block hold expander
// command and result words, effective configuration, register indexes
// no dependencies
`default_nettype none
package bhe_pkg;

  localparam int OpW      = 2;
  localparam int ChanW    = 3;
  localparam int FrameW   = 8;
  localparam int ValueW   = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int CountW   = 4;
  localparam int InBlkW   = 16;
  localparam int OutBlkW  = 9;
  localparam int ProdW    = 24;
  localparam int DivCntW  = 5;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IN_BLOCK      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OUT_BLOCK     = 2'd2;

  typedef enum logic [OpW-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e               op;
    logic [ChanW-1:0]   chan;
    logic [FrameW-1:0]  frame;
    logic [ValueW-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0]   chan;
    logic [ValueW-1:0]  value;
    logic               last;
  } res_t;

  // configuration after zero and saturation handling
  typedef struct packed {
    logic [CountW-1:0]  nch;
    logic [InBlkW-1:0]  ib;
    logic [OutBlkW-1:0] ob;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/bhe_fifo.sv
// bhe_fifo: small first-word-fall-through queue of flip-flops
// used for the command queue and the result queue; no dependencies
`default_nettype none
module bhe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bhe_front.sv
// bhe_front: accepts input words, classifies them and drops the ones that change nothing
// depends on bhe_pkg
`default_nettype none
module bhe_front #(
  parameter int MAX_CHANNELS  = 8,
  parameter int MAX_OUT_BLOCK = 256
) (
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [bhe_pkg::OpW-1:0]     operation_i,
  input  wire logic [bhe_pkg::ChanW-1:0]   chan_i,
  input  wire logic [bhe_pkg::FrameW-1:0]  frame_index_i,
  input  wire logic [bhe_pkg::ValueW-1:0]  frame_value_i,
  input  wire logic                        hold_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output bhe_pkg::cmd_t                    cmd_o
);
  import bhe_pkg::*;

  logic accept;
  logic keep;
  logic in_range;

  assign full_o   = q_full_i || hold_i;
  assign accept   = push_i && !full_o;
  assign in_range = (32'(chan_i) < MAX_CHANNELS) && (32'(frame_index_i) < MAX_OUT_BLOCK);

  always_comb begin
    case (operation_i)
      CMD_LOAD:   keep = in_range;
      CMD_COMMIT: keep = 1'b1;
      CMD_TICK:   keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign q_push_o    = accept && keep;
  assign cmd_o.op    = cmd_e'(operation_i);
  assign cmd_o.chan  = chan_i;
  assign cmd_o.frame = frame_index_i;
  assign cmd_o.value = frame_value_i;

endmodule
`default_nettype wire

>>> rtl/bhe_div.sv
// bhe_div: restoring divider, one quotient bit per cycle
// 24-bit dividend by 16-bit nonzero divisor; depends on bhe_pkg
`default_nettype none
module bhe_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bhe_pkg::ProdW-1:0]   dividend_i,
  input  wire logic [bhe_pkg::InBlkW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [bhe_pkg::ProdW-1:0]        quotient_o,
  output logic [bhe_pkg::InBlkW-1:0]       remainder_o
);
  import bhe_pkg::*;

  logic [ProdW-1:0]   quo_q;
  logic [InBlkW-1:0]  rem_q, dvs_q, rem_next;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [InBlkW:0]    rem_sh, rem_sub;
  logic               fits;

  assign rem_sh   = {rem_q, quo_q[ProdW-1]};
  assign fits     = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub  = rem_sh - {1'b0, dvs_q};
  assign rem_next = fits ? rem_sub[InBlkW-1:0] : rem_sh[InBlkW-1:0];

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(ProdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ProdW-2:0], fits};
      rem_q <= rem_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bhe_back.sv
// bhe_back: sequencer that executes commands against the pending and held stores
// clears the held store after reset, copies blocks, emits one word per channel on a tick
// depends on bhe_pkg and bhe_div
`default_nettype none
module bhe_back #(
  parameter int MAX_CHANNELS  = 8,
  parameter int MAX_OUT_BLOCK = 256,
  parameter int SAMPLE_BITS   = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bhe_pkg::cfg_t cfg_i,
  input  wire logic          cmd_empty_i,
  input  wire bhe_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output bhe_pkg::res_t      res_o,
  output logic               clearing_o
);
  import bhe_pkg::*;

  localparam int Depth = MAX_CHANNELS * MAX_OUT_BLOCK;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW    = (SAMPLE_BITS < ValueW) ? SAMPLE_BITS : ValueW;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_MOD_WAIT = 4'd2;
  localparam logic [3:0] ST_CHECK    = 4'd3;
  localparam logic [3:0] ST_COPY     = 4'd4;
  localparam logic [3:0] ST_MUL      = 4'd5;
  localparam logic [3:0] ST_DIVS     = 4'd6;
  localparam logic [3:0] ST_DIV_WAIT = 4'd7;
  localparam logic [3:0] ST_EMIT_RD  = 4'd8;
  localparam logic [3:0] ST_EMIT_WR  = 4'd9;
  localparam logic [3:0] ST_FINISH   = 4'd10;

  function automatic logic [AddrW-1:0] entry_addr(input logic [CountW-1:0] c,
                                                  input logic [FrameW-1:0] f);
    logic [31:0] a;
    a = 32'(c) * 32'(MAX_OUT_BLOCK) + 32'(f);
    return a[AddrW-1:0];
  endfunction

  logic [SW-1:0]      pend_mem [Depth];
  logic [SW-1:0]      held_mem [Depth];

  logic [3:0]         state_q;
  logic [AddrW-1:0]   clr_addr_q;
  logic               pend_valid_q;
  logic [InBlkW-1:0]  pos_q, phase_q;
  logic [CountW-1:0]  c_q;
  logic [FrameW-1:0]  j_q, frame_q;
  logic [ProdW-1:0]   prod_q;
  logic               cpy_wv_q;
  logic [AddrW-1:0]   cpy_wa_q;
  logic [SW-1:0]      pend_rd_q, held_rd_q;

  logic [CountW-1:0]  nch_m1;
  logic [OutBlkW-1:0] ob_m1_full;
  logic [FrameW-1:0]  ob_m1;
  logic               c_last, j_last;
  logic               tick_take, pend_we, pos_in_range;
  logic [AddrW-1:0]   pend_wa, cpy_ra, emit_ra;
  logic [OutBlkW+InBlkW-1:0] prod_full;
  logic [InBlkW:0]    phase_inc, pos_inc;

  logic               div_start, div_done;
  logic [ProdW-1:0]   div_dividend, div_quo;
  logic [InBlkW-1:0]  div_rem;

  assign nch_m1       = cfg_i.nch - 1'b1;
  assign ob_m1_full   = cfg_i.ob - 1'b1;
  assign ob_m1        = ob_m1_full[FrameW-1:0];
  assign c_last       = (c_q == nch_m1);
  assign j_last       = (j_q == ob_m1);
  assign pos_in_range = (pos_q < cfg_i.ib);

  assign clearing_o = (state_q == ST_CLEAR);
  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
  assign tick_take  = cmd_pop_o && (cmd_i.op == CMD_TICK);
  assign pend_we    = cmd_pop_o && (cmd_i.op == CMD_LOAD);
  assign pend_wa    = entry_addr({1'b0, cmd_i.chan}, cmd_i.frame);
  assign cpy_ra     = entry_addr(c_q, j_q);
  assign emit_ra    = entry_addr(c_q, frame_q);

  assign prod_full = phase_q * cfg_i.ob;
  assign phase_inc = {1'b0, phase_q} + 1'b1;
  assign pos_inc   = {1'b0, pos_q} + 1'b1;

  // the position is reduced only after in_block_size shrank to or below it
  assign div_start    = (tick_take && !pos_in_range) || (state_q == ST_DIVS);
  assign div_dividend = (state_q == ST_DIVS) ? prod_q : ProdW'(pos_q);

  bhe_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (cfg_i.ib),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign res_push_o  = (state_q == ST_EMIT_WR) && !res_full_i;
  assign res_o.chan  = c_q[ChanW-1:0];
  assign res_o.value = ValueW'(held_rd_q);
  assign res_o.last  = c_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      pend_valid_q <= 1'b0;
      pos_q        <= '0;
      phase_q      <= '0;
      c_q          <= '0;
      j_q          <= '0;
      cpy_wv_q     <= 1'b0;
    end else begin
      cpy_wv_q <= (state_q == ST_COPY);
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AddrW'(Depth - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop_o) begin
            case (cmd_i.op)
              CMD_COMMIT: pend_valid_q <= 1'b1;
              CMD_TICK:   state_q <= pos_in_range ? ST_CHECK : ST_MOD_WAIT;
              default:    ;
            endcase
          end
        end
        ST_MOD_WAIT: begin
          if (div_done) begin
            pos_q   <= div_rem;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          c_q <= '0;
          j_q <= '0;
          if ((pos_q == '0) && pend_valid_q) begin
            state_q <= ST_COPY;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_COPY: begin
          if (j_last) begin
            j_q <= '0;
            if (c_last) begin
              pend_valid_q <= 1'b0;
              phase_q      <= '0;
              state_q      <= ST_MUL;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_MUL:  state_q <= ST_DIVS;
        ST_DIVS: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            c_q     <= '0;
            state_q <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_WR;
        ST_EMIT_WR: begin
          if (!res_full_i) begin
            if (c_last) begin
              state_q <= ST_FINISH;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= ST_EMIT_RD;
            end
          end
        end
        ST_FINISH: begin
          phase_q <= (phase_inc > {1'b0, cfg_i.ib}) ? cfg_i.ib : phase_inc[InBlkW-1:0];
          pos_q   <= (pos_inc == {1'b0, cfg_i.ib}) ? '0 : pos_inc[InBlkW-1:0];
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cpy_wa_q <= cpy_ra;
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[ProdW-1:0];
    end
    if ((state_q == ST_DIV_WAIT) && div_done) begin
      frame_q <= (div_quo > ProdW'(ob_m1)) ? ob_m1 : div_quo[FrameW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= cmd_i.value[SW-1:0];
    end
    if (state_q == ST_COPY) begin
      pend_rd_q <= pend_mem[cpy_ra];
    end
  end

  // copy writes land in the cycle after their pending read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      held_mem[clr_addr_q] <= '0;
    end else if (cpy_wv_q) begin
      held_mem[cpy_wa_q] <= pend_rd_q;
    end
    if (state_q == ST_EMIT_RD) begin
      held_rd_q <= held_mem[emit_ra];
    end
  end

endmodule
`default_nettype wire

>>> rtl/block_hold_expander_top.sv
// block_hold_expander_top: top level of the block hold expander
// holds the configuration registers; depends on bhe_pkg, bhe_fifo, bhe_front, bhe_back
//
// Sample-rate expander: load words fill a pending block of frames per channel, a commit
// word marks it valid, and each tick word emits one held frame per channel, picked by
// the hold phase times out_block_size over the host block length and clamped to the last
// frame. After reset a clearing pass zeroes the held store, one entry a cycle, with full
// high throughout. Loads and commits are handled by the back end while it is idle; words
// with an unused operation are dropped at the front and never reach it. A tick first
// reduces the position with the bit-serial divider when the host block length shrank,
// copies a pending block into the held store when one is valid at position zero, then
// runs the divider for the frame index and does one held-store read and one result
// write per channel. A four-word queue on each side lets input and output stall
// independently.
`default_nettype none
module block_hold_expander_top #(
  parameter int MAX_CHANNELS  = 8,
  parameter int MAX_OUT_BLOCK = 256,
  parameter int SAMPLE_BITS   = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bhe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bhe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [bhe_pkg::OpW-1:0]       operation_i,
  input  wire logic [bhe_pkg::ChanW-1:0]     chan_i,
  input  wire logic [bhe_pkg::FrameW-1:0]    frame_index_i,
  input  wire logic signed [bhe_pkg::ValueW-1:0] frame_value_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [bhe_pkg::ChanW-1:0]          out_chan_o,
  output logic signed [bhe_pkg::ValueW-1:0]  out_value_o,
  output logic                               last_chan_o
);
  import bhe_pkg::*;

  localparam int QDepth  = 4;
  localparam int ChanCap = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

  logic [CountW-1:0]  cc_q;
  logic [InBlkW-1:0]  ib_q;
  logic [OutBlkW-1:0] ob_q;
  cfg_t               cfg_eff;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;
  logic clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= CountW'(1);
      ib_q <= InBlkW'(2);
      ob_q <= OutBlkW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHANNEL_COUNT: cc_q <= cfg_data_i[CountW-1:0];
        CFG_IN_BLOCK:      ib_q <= cfg_data_i[InBlkW-1:0];
        CFG_OUT_BLOCK:     ob_q <= cfg_data_i[OutBlkW-1:0];
        default:           ;
      endcase
    end
  end

  // zero acts as one, too large saturates
  assign cfg_eff.nch = (cc_q == '0) ? CountW'(1) :
                       (32'(cc_q) > ChanCap) ? CountW'(ChanCap) : cc_q;
  assign cfg_eff.ib  = (ib_q == '0) ? InBlkW'(1) : ib_q;
  assign cfg_eff.ob  = (ob_q == '0) ? OutBlkW'(1) :
                       (32'(ob_q) > MAX_OUT_BLOCK) ? OutBlkW'(MAX_OUT_BLOCK) : ob_q;

  bhe_front #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .MAX_OUT_BLOCK (MAX_OUT_BLOCK)
  ) u_front (
    .push_i        (push),
    .full_o        (full),
    .operation_i   (operation_i),
    .chan_i        (chan_i),
    .frame_index_i (frame_index_i),
    .frame_value_i (frame_value_i),
    .hold_i        (clearing),
    .q_full_i      (cmd_full),
    .q_push_o      (cmd_push),
    .cmd_o         (cmd_in)
  );

  bhe_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  bhe_back #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .MAX_OUT_BLOCK (MAX_OUT_BLOCK),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_eff),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  bhe_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign out_chan_o  = res_out.chan;
  assign out_value_o = res_out.value;
  assign last_chan_o = res_out.last;

  a_no_push_into_full_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result word written into a full result queue");

  a_no_cmd_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!cmd_push && !cmd_pop))
    else $error("command moved during the held store clearing pass");

  a_last_on_final_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_chan_o) |-> ({1'b0, out_chan_o} == (cfg_eff.nch - 1'b1)))
    else $error("last channel flag on a channel other than the final one");

endmodule
`default_nettype wire
